// ===== hw/rtl/apc_pkg.sv =====
// shared types and constants of the alignment pileup counter
package apc_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] EDIT_MATCH    = 2'd0;
    localparam logic [1:0] EDIT_DEL      = 2'd1;
    localparam logic [1:0] EDIT_INS      = 2'd2;
    localparam logic [1:0] EDIT_MISMATCH = 2'd3;

    localparam logic [7:0] BASE_A = 8'h41;
    localparam logic [7:0] BASE_C = 8'h43;
    localparam logic [7:0] BASE_G = 8'h47;
    localparam logic [7:0] BASE_T = 8'h54;

    localparam int NUM_SLOTS = 6;
    localparam int SLOT_A    = 0;
    localparam int SLOT_C    = 1;
    localparam int SLOT_G    = 2;
    localparam int SLOT_T    = 3;
    localparam int SLOT_DEL  = 4;
    localparam int SLOT_INS  = 5;

    localparam int CURSOR_W = 17;
    localparam logic [CURSOR_W-1:0] CURSOR_MAX = '1;
    localparam int LEN_W = 17;
    localparam logic [LEN_W-1:0] READ_LENGTH_RESET = 17'h10000;
    localparam int FIELD_W = 16;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic       is_read;
        logic [1:0] edit;
        logic [7:0] base;
    } t_upd_ctrl;

endpackage

// ===== hw/rtl/apc_item_if.sv =====
// input item channel of the alignment pileup counter
interface apc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] start_position;
    logic [1:0]  edit_code;
    logic [7:0]  target_base;
    logic [15:0] read_address;
    logic        clear_after_read;

    modport source (
        output valid, op, start_position, edit_code, target_base, read_address,
               clear_after_read,
        input  ready
    );
    modport sink (
        input  valid, op, start_position, edit_code, target_base, read_address,
               clear_after_read,
        output ready
    );
endinterface

// ===== hw/rtl/apc_result_if.sv =====
// result item channel of the alignment pileup counter
interface apc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] count_a;
    logic [15:0] count_c;
    logic [15:0] count_g;
    logic [15:0] count_t;
    logic [15:0] count_deletion;
    logic [15:0] count_insertion;

    modport source (
        output valid, count_a, count_c, count_g, count_t, count_deletion,
               count_insertion,
        input  ready
    );
    modport sink (
        input  valid, count_a, count_c, count_g, count_t, count_deletion,
               count_insertion,
        output ready
    );
endinterface

// ===== hw/rtl/apc_row_update.sv =====
// modify stage: bumps one saturating counter of a pileup row or clears it
module apc_row_update
    import apc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  t_upd_ctrl                         i_ctrl,
    input  logic [NUM_SLOTS*COUNT_BITS-1:0]   i_row,
    output logic [NUM_SLOTS*COUNT_BITS-1:0]   o_row
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [NUM_SLOTS-1:0] w_hit;

    always_comb begin
        w_hit = '0;
        case (i_ctrl.edit)
            EDIT_MATCH, EDIT_MISMATCH: begin
                case (i_ctrl.base)
                    BASE_A:  w_hit[SLOT_A] = 1'b1;
                    BASE_C:  w_hit[SLOT_C] = 1'b1;
                    BASE_G:  w_hit[SLOT_G] = 1'b1;
                    BASE_T:  w_hit[SLOT_T] = 1'b1;
                    default: w_hit = '0;
                endcase
            end
            EDIT_DEL: w_hit[SLOT_DEL] = 1'b1;
            EDIT_INS: w_hit[SLOT_INS] = 1'b1;
            default:  w_hit = '0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (i_ctrl.is_read) begin
                o_row[k*COUNT_BITS +: COUNT_BITS] = '0;
            end else if (w_hit[k] && (i_row[k*COUNT_BITS +: COUNT_BITS] != CNT_MAX)) begin
                o_row[k*COUNT_BITS +: COUNT_BITS] =
                    i_row[k*COUNT_BITS +: COUNT_BITS] + COUNT_BITS'(1);
            end else begin
                o_row[k*COUNT_BITS +: COUNT_BITS] = i_row[k*COUNT_BITS +: COUNT_BITS];
            end
        end
    end

endmodule

// ===== hw/rtl/alignment_pileup_counter_unit.sv =====
// alignment pileup counter: top level with counter memory and item sequencing
// All six counters of a position share one row of a single-port-write memory with a
// registered read. After reset the block sweeps the memory to zero, one row a cycle,
// and takes no item meanwhile; the read_length register can be written at any time. A
// start item, an unused op and a step whose position lies outside the read or the memory
// are done when taken, and the block stays idle. For a counting step and a read item the
// row is read when the item is taken and is written back, or returned, in the update
// state. A read item waits in the update state while an earlier result has not yet been
// taken. Results come from an output register, so new items are taken while a result
// waits.
module alignment_pileup_counter_unit
    import apc_pkg::*;
#(
    parameter int PILE_DEPTH = 65536,
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LEN_W-1:0]   i_cfg_wdata,
    apc_item_if.sink           i_item,
    apc_result_if.source       o_result
);

    localparam int AW    = $clog2(PILE_DEPTH);
    localparam int ROW_W = NUM_SLOTS * COUNT_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PILE_DEPTH - 1);

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_clr_addr, n_clr_addr;
    logic [LEN_W-1:0]       r_read_length;
    logic [CURSOR_W-1:0]    r_cursor, n_cursor;
    logic                   r_out_valid, n_out_valid;
    logic [FIELD_W-1:0]     r_out_cnt [NUM_SLOTS];

    t_upd_ctrl              r_ctrl;
    logic                   r_clear;
    logic                   r_in_range;
    logic [AW-1:0]          r_addr;

    logic [ROW_W-1:0]       r_mem [PILE_DEPTH];
    logic [ROW_W-1:0]       r_rd_row;
    logic [ROW_W-1:0]       w_upd_row;

    logic                   w_acc;
    logic                   w_live;
    logic                   w_rd_in_range;
    logic [31:0]            w_raddr32;
    logic                   w_mem_re;
    logic                   w_mem_we;
    logic [AW-1:0]          w_mem_waddr;
    logic [ROW_W-1:0]       w_mem_wdata;
    logic                   w_upd_go;
    logic                   w_load_out;

    assign w_acc         = i_item.valid && i_item.ready;
    assign w_live        = (32'(r_cursor) < 32'(r_read_length)) &&
                           (32'(r_cursor) < 32'(PILE_DEPTH));
    assign w_rd_in_range = 32'(i_item.read_address) < 32'(PILE_DEPTH);
    assign w_raddr32     = (i_item.op == OP_READ) ? 32'(i_item.read_address)
                                                  : 32'(r_cursor);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc && (i_item.op == OP_READ || (i_item.op == OP_STEP && w_live))) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (w_upd_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        i_item.ready = (r_state == S_IDLE);
        w_upd_go     = !r_ctrl.is_read || !r_out_valid || o_result.ready;
        w_mem_re     = w_acc;
        w_mem_we     = 1'b0;
        w_mem_waddr  = r_addr;
        w_mem_wdata  = w_upd_row;
        w_load_out   = 1'b0;
        n_clr_addr   = r_clr_addr;
        case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_addr;
                w_mem_wdata = '0;
                n_clr_addr  = r_clr_addr + AW'(1);
            end
            S_UPDATE: begin
                w_load_out = w_upd_go && r_ctrl.is_read;
                w_mem_we   = w_upd_go && (!r_ctrl.is_read || (r_clear && r_in_range));
            end
            default: w_mem_we = 1'b0;
        endcase

        n_cursor = r_cursor;
        if (w_acc && i_item.op == OP_START) begin
            n_cursor = CURSOR_W'(i_item.start_position);
        end else if (w_acc && i_item.op == OP_STEP && i_item.edit_code != EDIT_INS &&
                     r_cursor != CURSOR_MAX) begin
            n_cursor = r_cursor + CURSOR_W'(1);
        end

        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    apc_row_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_row_update (
        .i_ctrl (r_ctrl),
        .i_row  (r_rd_row),
        .o_row  (w_upd_row)
    );

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_row <= r_mem[w_raddr32[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_read_length <= READ_LENGTH_RESET;
            r_cursor      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_read_length <= i_cfg_wdata;
            end
        end
    end

    // captured item and result payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ctrl.is_read <= (i_item.op == OP_READ);
            r_ctrl.edit    <= i_item.edit_code;
            r_ctrl.base    <= i_item.target_base;
            r_clear        <= i_item.clear_after_read;
            r_in_range     <= w_rd_in_range;
            r_addr         <= w_raddr32[AW-1:0];
        end
        if (w_load_out) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_out_cnt[k] <= r_in_range
                    ? FIELD_W'(32'(r_rd_row[k*COUNT_BITS +: COUNT_BITS])) : '0;
            end
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.count_a         = r_out_cnt[SLOT_A];
    assign o_result.count_c         = r_out_cnt[SLOT_C];
    assign o_result.count_g         = r_out_cnt[SLOT_G];
    assign o_result.count_t         = r_out_cnt[SLOT_T];
    assign o_result.count_deletion  = r_out_cnt[SLOT_DEL];
    assign o_result.count_insertion = r_out_cnt[SLOT_INS];

    a_read_goes_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_item.op == OP_READ) |=> (r_state == S_UPDATE))
        else $error("read item did not enter the update cycle");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_UPDATE && $past(r_ctrl.is_read)))
        else $error("result raised outside a read update");

    a_cursor_moves_on_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(w_acc)) |-> $stable(r_cursor))
        else $error("cursor changed without an item");

    a_no_write_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_mem_we)
        else $error("memory written while idle");

endmodule
